// ----- design/rmq_pkg.sv -----
// Shared types and constants for the rotation matrix to quaternion unit.
// Holds the fixed-point format, the control struct, branch codes and a saturation helper; no dependencies.
package rmq_pkg;
  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS = 14;
  // Radicand: sum of three elements and one, needs DATA_WIDTH+2 bits.
  localparam int RAD_W = DATA_WIDTH + 2;
  // Root argument R << F, nonnegative.
  localparam int SQA_W = RAD_W + FRAC_BITS;
  localparam int SQ_W = (SQA_W + 1) / 2;
  // Off-diagonal sums and differences.
  localparam int DIF_W = DATA_WIDTH + 1;
  // Dividend: |d| << F plus half the divisor.
  localparam int NUM_W = DIF_W + FRAC_BITS + 1;
  localparam int DEN_W = SQ_W + 1;
  localparam int QUO_W = NUM_W;

  typedef enum logic [1:0] {
    BIG_X = 2'd0,
    BIG_Y = 2'd1,
    BIG_Z = 2'd2,
    BIG_W = 2'd3
  } big_t;

  typedef struct packed {
    logic valid;
    logic degenerate;
    big_t big;
  } ctl_t;

  function automatic logic signed [DATA_WIDTH-1:0] sat_field(
      input logic signed [QUO_W:0] v);
    logic signed [QUO_W:0] hi;
    logic signed [QUO_W:0] lo;
    begin
      hi = (QUO_W+1)'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
      lo = -hi - (QUO_W+1)'(1);
      if (v > hi) sat_field = hi[DATA_WIDTH-1:0];
      else if (v < lo) sat_field = lo[DATA_WIDTH-1:0];
      else sat_field = v[DATA_WIDTH-1:0];
    end
  endfunction
endpackage

// ----- design/rotation_matrix_to_quaternion_unit.sv -----
// Top level of the rotation matrix to quaternion unit (Shepperd's method).
// Depends on rmq_pkg, rmq_sqrt_pipe and rmq_div_pipe.
//
// Usage:
//   Drive r11..r33 (signed Q2.14) and pulse start; busy is always low, so a
//   beat is taken on every cycle start is high. One matrix a cycle.
//   Each result beat appears on qx, qy, qz, qw, degenerate with done high for
//   exactly one cycle; the receiver cannot stall and must take it then.
// Path: an accepted beat passes the stage 0 register, the one-bit-per-stage root
//   pipeline, the stage 1 register, the one-bit-per-stage divider and the
//   stage 2 register before done is high.
// Throughput: one beat per cycle, back to back, with results in input order.
// Pipeline:
//   stage 0  branch select, radicand and off-diagonal terms
//   root     restoring square root of R << F, one bit per stage
//   stage 1  dividend setup with rounding offset, sign split
//   divide   three parallel quotients of |d| << F by 2*root
//   stage 2  sign restore, placement, saturation, identity on degenerate
// Reset: rst clears every valid bit; items in flight are dropped.
module rotation_matrix_to_quaternion_unit
  import rmq_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [DATA_WIDTH-1:0]  r11,
  input  logic signed [DATA_WIDTH-1:0]  r12,
  input  logic signed [DATA_WIDTH-1:0]  r13,
  input  logic signed [DATA_WIDTH-1:0]  r21,
  input  logic signed [DATA_WIDTH-1:0]  r22,
  input  logic signed [DATA_WIDTH-1:0]  r23,
  input  logic signed [DATA_WIDTH-1:0]  r31,
  input  logic signed [DATA_WIDTH-1:0]  r32,
  input  logic signed [DATA_WIDTH-1:0]  r33,
  output logic                          done,
  output logic signed [DATA_WIDTH-1:0]  qx,
  output logic signed [DATA_WIDTH-1:0]  qy,
  output logic signed [DATA_WIDTH-1:0]  qz,
  output logic signed [DATA_WIDTH-1:0]  qw,
  output logic                          degenerate
);
  // Never back-pressure: every stage advances every cycle.
  assign busy = 1'b0;

  localparam logic signed [RAD_W-1:0] ONE_FX = RAD_W'(1) << FRAC_BITS;

  // Stage 0: branch select.
  logic signed [RAD_W-1:0] e11, e22, e33, tr, rad_next;
  logic signed [DIF_W-1:0] d0_next, d1_next, d2_next;
  big_t                    big_next;

  always_comb begin
    e11 = RAD_W'(r11);
    e22 = RAD_W'(r22);
    e33 = RAD_W'(r33);
    tr = e11 + e22 + e33;
    if (tr > 0) begin
      big_next = BIG_W;
      rad_next = tr + ONE_FX;
      d0_next = DIF_W'(r32) - DIF_W'(r23);
      d1_next = DIF_W'(r13) - DIF_W'(r31);
      d2_next = DIF_W'(r21) - DIF_W'(r12);
    end else if (r11 > r22 && r11 > r33) begin
      big_next = BIG_X;
      rad_next = ONE_FX + e11 - e22 - e33;
      d0_next = DIF_W'(r12) + DIF_W'(r21);
      d1_next = DIF_W'(r13) + DIF_W'(r31);
      d2_next = DIF_W'(r32) - DIF_W'(r23);
    end else if (r22 > r33) begin
      big_next = BIG_Y;
      rad_next = ONE_FX + e22 - e11 - e33;
      d0_next = DIF_W'(r12) + DIF_W'(r21);
      d1_next = DIF_W'(r23) + DIF_W'(r32);
      d2_next = DIF_W'(r13) - DIF_W'(r31);
    end else begin
      big_next = BIG_Z;
      rad_next = ONE_FX + e33 - e11 - e22;
      d0_next = DIF_W'(r13) + DIF_W'(r31);
      d1_next = DIF_W'(r23) + DIF_W'(r32);
      d2_next = DIF_W'(r21) - DIF_W'(r12);
    end
  end

  ctl_t                       s0_ctl;
  logic [SQA_W-1:0]           s0_arg;
  logic signed [3*DIF_W-1:0]  s0_dif;

  always_ff @(posedge clk) begin
    if (rst) s0_ctl.valid <= 1'b0;
    else s0_ctl.valid <= start;
    s0_ctl.big <= big_next;
    s0_ctl.degenerate <= (rad_next <= 0);
    // Hold a zero argument for degenerate items; the root then reads zero.
    s0_arg <= (rad_next > 0) ? {rad_next[RAD_W-2:0], {FRAC_BITS{1'b0}}, 1'b0} >> 1
                             : '0;
    s0_dif <= {d2_next, d1_next, d0_next};
  end

  // Root pipeline.
  ctl_t                       rt_ctl;
  logic [SQ_W-1:0]            rt_root;
  logic signed [3*DIF_W-1:0]  rt_dif;

  rmq_sqrt_pipe u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .ctl_in   (s0_ctl),
    .arg_in   (s0_arg),
    .dif_in   (s0_dif),
    .ctl_out  (rt_ctl),
    .root_out (rt_root),
    .dif_out  (rt_dif)
  );

  // Stage 1: dividend = |d| << F + root (half of 2*root).
  ctl_t               s1_ctl;
  logic [SQ_W-1:0]    s1_root;
  logic [3*NUM_W-1:0] s1_num;
  logic [2:0]         s1_neg;
  logic [3*NUM_W-1:0] num_next;
  logic [2:0]         neg_next;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      logic signed [DIF_W-1:0] d;
      logic [DIF_W-1:0]        mag;
      d = rt_dif[j*DIF_W +: DIF_W];
      neg_next[j] = d[DIF_W-1];
      mag = d[DIF_W-1] ? DIF_W'(-d) : DIF_W'(d);
      num_next[j*NUM_W +: NUM_W] = (NUM_W'(mag) << FRAC_BITS) + NUM_W'(rt_root);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) s1_ctl.valid <= 1'b0;
    else s1_ctl.valid <= rt_ctl.valid;
    s1_ctl.big <= rt_ctl.big;
    s1_ctl.degenerate <= rt_ctl.degenerate || (rt_root == '0);
    // Keep the divisor nonzero so degenerate items stay harmless.
    s1_root <= (rt_root == '0) ? SQ_W'(1) : rt_root;
    s1_num <= num_next;
    s1_neg <= neg_next;
  end

  // Divider pipeline.
  ctl_t               dv_ctl;
  logic [SQ_W-1:0]    dv_root;
  logic [3*QUO_W-1:0] dv_quo;
  logic [2:0]         dv_neg;

  rmq_div_pipe u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl_in   (s1_ctl),
    .root_in  (s1_root),
    .num_in   (s1_num),
    .neg_in   (s1_neg),
    .ctl_out  (dv_ctl),
    .root_out (dv_root),
    .quo_out  (dv_quo),
    .neg_out  (dv_neg)
  );

  // Stage 2: sign restore, placement and saturation.
  logic signed [DATA_WIDTH-1:0] sv [3];
  logic signed [DATA_WIDTH-1:0] half_root;
  logic signed [DATA_WIDTH-1:0] qx_next, qy_next, qz_next, qw_next;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      logic signed [QUO_W:0] qv;
      qv = {1'b0, dv_quo[j*QUO_W +: QUO_W]};
      sv[j] = sat_field(dv_neg[j] ? -qv : qv);
    end
    half_root = sat_field((QUO_W+1)'((SQ_W+1)'(dv_root) + (SQ_W+1)'(1)) >>> 1);
    unique case (dv_ctl.big)
      BIG_W: begin
        qx_next = sv[0]; qy_next = sv[1]; qz_next = sv[2]; qw_next = half_root;
      end
      BIG_X: begin
        qx_next = half_root; qy_next = sv[0]; qz_next = sv[1]; qw_next = sv[2];
      end
      BIG_Y: begin
        qx_next = sv[0]; qy_next = half_root; qz_next = sv[1]; qw_next = sv[2];
      end
      default: begin
        qx_next = sv[0]; qy_next = sv[1]; qz_next = half_root; qw_next = sv[2];
      end
    endcase
    if (dv_ctl.degenerate) begin
      qx_next = '0;
      qy_next = '0;
      qz_next = '0;
      qw_next = sat_field((QUO_W+1)'(1) << FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= dv_ctl.valid;
    qx <= qx_next;
    qy <= qy_next;
    qz <= qz_next;
    qw <= qw_next;
    degenerate <= dv_ctl.degenerate;
  end
endmodule

// ----- design/rmq_sqrt_pipe.sv -----
// Pipelined integer square root: one result bit per stage, one operand per cycle.
// Depends on rmq_pkg; carries control and off-diagonal terms alongside.
module rmq_sqrt_pipe
  import rmq_pkg::*;
(
  input  logic                           clk,
  input  logic                           rst,
  input  ctl_t                           ctl_in,
  input  logic [SQA_W-1:0]               arg_in,
  input  logic signed [3*DIF_W-1:0]      dif_in,
  output ctl_t                           ctl_out,
  output logic [SQ_W-1:0]                root_out,
  output logic signed [3*DIF_W-1:0]      dif_out
);
  // Stage k decides root bit SQ_W-1-k with a restoring step.
  ctl_t                       ctl [SQ_W+1];
  logic [SQA_W-1:0]           rem [SQ_W+1];
  logic [SQ_W-1:0]            root [SQ_W+1];
  logic signed [3*DIF_W-1:0]  dif [SQ_W+1];

  always_comb begin
    ctl[0] = ctl_in;
    rem[0] = arg_in;
    root[0] = '0;
    dif[0] = dif_in;
  end

  for (genvar k = 0; k < SQ_W; k++) begin : g_stage
    localparam int B = SQ_W - 1 - k;
    logic [SQA_W-1:0] trial;
    logic [SQ_W-1:0]  cand;
    // Compare candidate square against the operand carried in rem.
    always_comb begin
      cand = root[k] | (SQ_W'(1) << B);
      trial = SQA_W'(cand) * SQA_W'(cand);
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        ctl[k+1].valid <= 1'b0;
      end else begin
        ctl[k+1].valid <= ctl[k].valid;
      end
      ctl[k+1].degenerate <= ctl[k].degenerate;
      ctl[k+1].big <= ctl[k].big;
      rem[k+1] <= rem[k];
      dif[k+1] <= dif[k];
      root[k+1] <= (trial <= rem[k]) ? cand : root[k];
    end
  end

  assign ctl_out = ctl[SQ_W];
  assign root_out = root[SQ_W];
  assign dif_out = dif[SQ_W];
endmodule

// ----- design/rmq_div_pipe.sv -----
// Pipelined restoring divider for the three scaled quotients, one bit per stage.
// Depends on rmq_pkg; magnitudes only, signs travel alongside.
module rmq_div_pipe
  import rmq_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  ctl_t                ctl_in,
  input  logic [SQ_W-1:0]     root_in,
  input  logic [3*NUM_W-1:0]  num_in,
  input  logic [2:0]          neg_in,
  output ctl_t                ctl_out,
  output logic [SQ_W-1:0]     root_out,
  output logic [3*QUO_W-1:0]  quo_out,
  output logic [2:0]          neg_out
);
  ctl_t               ctl [QUO_W+1];
  logic [SQ_W-1:0]    root [QUO_W+1];
  logic [2:0]         neg [QUO_W+1];
  logic [NUM_W-1:0]   num [QUO_W+1][3];
  logic [DEN_W:0]     rem [QUO_W+1][3];
  logic [QUO_W-1:0]   quo [QUO_W+1][3];

  always_comb begin
    ctl[0] = ctl_in;
    root[0] = root_in;
    neg[0] = neg_in;
    for (int j = 0; j < 3; j++) begin
      num[0][j] = num_in[j*NUM_W +: NUM_W];
      rem[0][j] = '0;
      quo[0][j] = '0;
    end
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic [DEN_W-1:0] den;
    logic [DEN_W:0]   sh [3];
    assign den = {root[k], 1'b0};
    always_comb begin
      for (int j = 0; j < 3; j++)
        sh[j] = {rem[k][j][DEN_W-1:0], num[k][j][NUM_W-1-k]};
    end
    always_ff @(posedge clk) begin
      if (rst) ctl[k+1].valid <= 1'b0;
      else ctl[k+1].valid <= ctl[k].valid;
      ctl[k+1].degenerate <= ctl[k].degenerate;
      ctl[k+1].big <= ctl[k].big;
      root[k+1] <= root[k];
      neg[k+1] <= neg[k];
      for (int j = 0; j < 3; j++) begin
        num[k+1][j] <= num[k][j];
        if (sh[j] >= {1'b0, den}) begin
          rem[k+1][j] <= sh[j] - {1'b0, den};
          quo[k+1][j] <= quo[k][j] | (QUO_W'(1) << (QUO_W - 1 - k));
        end else begin
          rem[k+1][j] <= sh[j];
          quo[k+1][j] <= quo[k][j];
        end
      end
    end
  end

  assign ctl_out = ctl[QUO_W];
  assign root_out = root[QUO_W];
  assign neg_out = neg[QUO_W];
  always_comb
    for (int j = 0; j < 3; j++) quo_out[j*QUO_W +: QUO_W] = quo[QUO_W][j];
endmodule
